/* rtl/multi_voter_watchdog_monitor_top_assert.svh */
// Assertion macros for the watchdog monitor top level.
// No dependencies; included by multi_voter_watchdog_monitor_top.sv.
`ifndef MULTI_VOTER_WATCHDOG_MONITOR_TOP_ASSERT_SVH
`define MULTI_VOTER_WATCHDOG_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MVWD_ASSERT_NOW(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("mvwd assertion failed");

// Next-cycle implication, held off during reset.
`define MVWD_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("mvwd assertion failed");

`endif

/* rtl/mvwd_pkg.sv */
// Shared types and constants for the watchdog monitor.
// No dependencies; imported by every module of the block.
package mvwd_pkg;

  localparam int unsigned MASK_W = 8;   // width of the voter masks
  localparam int unsigned IDX_W  = 8;   // width of the voter index field
  localparam int unsigned CNT_W  = 32;  // vote counters and totals
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic FUNC_VOTE = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STALL    = 1'b1;

  localparam logic [MASK_W-1:0] REQUIRED_RST = 8'h01;
  localparam logic [MASK_W-1:0] STALL_RST    = 8'h00;

  // One committed operation, passed from the input stage to the voter bank.
  typedef struct packed {
    logic              vote;
    logic              eval;
    logic [IDX_W-1:0]  idx;
  } mvwd_op_t;

endpackage

/* rtl/mvwd_voter_bank.sv */
// Per-voter vote counters, snapshots and missing compare.
// Depends on mvwd_pkg.
module mvwd_voter_bank
  import mvwd_pkg::*;
#(
  parameter int unsigned VOTERS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mvwd_op_t          op_i,
  input  logic [MASK_W-1:0] need_mask_i,
  input  logic [MASK_W-1:0] stall_mask_i,
  output logic [MASK_W-1:0] absent_mask_o
);

  logic [VOTERS-1:0] missing_lane;

  for (genvar gi = 0; gi < VOTERS; gi++) begin : g_lane
    logic [CNT_W-1:0] vote_q, vote_d;
    logic [CNT_W-1:0] seen_q;
    logic             req, stl, hit;

    if (gi < MASK_W) begin : g_masked
      assign req = need_mask_i[gi];
      assign stl = stall_mask_i[gi];
    end else begin : g_unmasked
      assign req = 1'b0;
      assign stl = 1'b0;
    end

    assign hit    = op_i.vote && (op_i.idx == IDX_W'(gi)) && !stl;
    assign vote_d = hit ? vote_q + CNT_W'(1) : vote_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vote_q <= '0;
        seen_q <= '0;
      end else begin
        vote_q <= vote_d;
        // snapshot on evaluate
        if (op_i.eval) begin
          seen_q <= vote_q;
        end
      end
    end

    assign missing_lane[gi] = req && (vote_q == seen_q);
  end

  for (genvar gb = 0; gb < MASK_W; gb++) begin : g_mask_bit
    if (gb < VOTERS) begin : g_live
      assign absent_mask_o[gb] = missing_lane[gb];
    end else begin : g_absent
      assign absent_mask_o[gb] = 1'b0;
    end
  end

endmodule

/* rtl/mvwd_result.sv */
// Evaluation totals and the registered result beat.
// Depends on mvwd_pkg.
module mvwd_result
  import mvwd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              eval_go_i,
  input  logic [MASK_W-1:0] missing_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              healthy_o,
  output logic [MASK_W-1:0] absent_mask_o,
  output logic [CNT_W-1:0]  evaluation_total_o,
  output logic [CNT_W-1:0]  healthy_total_o
);

  logic              valid_q;
  logic              healthy_q;
  logic [MASK_W-1:0] missing_q;
  logic [CNT_W-1:0]  eval_cnt_q, eval_cnt_d;
  logic [CNT_W-1:0]  healthy_cnt_q, healthy_cnt_d;
  logic              healthy_d;

  assign healthy_d     = (missing_i == '0);
  assign eval_cnt_d    = eval_cnt_q + CNT_W'(1);
  assign healthy_cnt_d = healthy_cnt_q + CNT_W'(healthy_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= 1'b0;
      eval_cnt_q    <= '0;
      healthy_cnt_q <= '0;
    end else if (eval_go_i) begin
      valid_q       <= 1'b1;
      eval_cnt_q    <= eval_cnt_d;
      healthy_cnt_q <= healthy_cnt_d;
    end else if (!out_stall_i) begin
      valid_q       <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_go_i) begin
      healthy_q <= healthy_d;
      missing_q <= missing_i;
    end
  end

  assign out_valid_o        = valid_q;
  assign healthy_o          = healthy_q;
  assign absent_mask_o      = missing_q;
  assign evaluation_total_o = eval_cnt_q;
  assign healthy_total_o    = healthy_cnt_q;

endmodule

/* rtl/multi_voter_watchdog_monitor_top.sv */
// Multi-voter heartbeat watchdog monitor, top level.
// Depends on mvwd_pkg, mvwd_voter_bank, mvwd_result and the assertion header.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per operation:
//   func_i selects a vote (voter_index_i names the voter) or an evaluate.
//   A vote updates that voter's counter (unless its stall bit is set) and produces no output beat.
//   An evaluate produces exactly one output beat (out_valid_o / out_stall_i)
//   with the healthy flag, the mask of required voters that did not vote
//   since the previous evaluate, and the evaluation and healthy totals.
//   Timing: an accepted beat is held in the input register until it
//   commits; an evaluate's result is then registered in the result
//   register and shown on the output channel.
//   Throughput: one beat per cycle while in_stall_o is low; every voter
//   lane is compared in parallel. Stalling: the result register holds its
//   beat while out_stall_i is high. Votes keep flowing past a stalled
//   result; an evaluate waits in the input register until the result beat
//   is taken, and in_stall_o stays raised while it waits.
//   Reset: all counters, snapshots and totals clear, the required mask
//   returns to voter 0 only and stall_mask to none. Write masks only idle.
`include "multi_voter_watchdog_monitor_top_assert.svh"

module multi_voter_watchdog_monitor_top
  import mvwd_pkg::*;
#(
  parameter int unsigned VOTERS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MASK_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [IDX_W-1:0]     voter_index_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 healthy_o,
  output logic [MASK_W-1:0]    absent_mask_o,
  output logic [CNT_W-1:0]     evaluation_total_o,
  output logic [CNT_W-1:0]     healthy_total_o
);

  // Configuration registers
  logic [MASK_W-1:0] required_q;
  logic [MASK_W-1:0] stall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      required_q <= REQUIRED_RST;
      stall_q    <= STALL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REQUIRED: required_q <= cfg_wdata_i;
        REG_STALL:    stall_q    <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // Input register: holds one beat until it commits
  logic             s1_valid_q;
  logic             s1_func_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             res_free;
  logic             s1_go;
  logic             in_accept;
  mvwd_op_t         op;
  logic [MASK_W-1:0] missing;

  // A vote always commits; an evaluate commits once the result slot frees.
  assign res_free   = !out_valid_o || !out_stall_i;
  assign s1_go      = s1_valid_q && ((s1_func_q == FUNC_VOTE) || res_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q <= func_i;
      s1_idx_q  <= voter_index_i;
    end
  end

  assign op.vote = s1_go && (s1_func_q == FUNC_VOTE);
  assign op.eval = s1_go && (s1_func_q == FUNC_EVAL);
  assign op.idx  = s1_idx_q;

  mvwd_voter_bank #(
    .VOTERS (VOTERS)
  ) u_bank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .need_mask_i   (required_q),
    .stall_mask_i  (stall_q),
    .absent_mask_o (missing)
  );

  mvwd_result u_result (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .eval_go_i          (op.eval),
    .missing_i          (missing),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .healthy_o          (healthy_o),
    .absent_mask_o      (absent_mask_o),
    .evaluation_total_o (evaluation_total_o),
    .healthy_total_o    (healthy_total_o)
  );

  // Checks
  `MVWD_ASSERT_NOW(a_healthy_matches_mask, clk_i, rst_ni,
    out_valid_o, healthy_o == (absent_mask_o == '0))
  `MVWD_ASSERT_NEXT(a_eval_gives_beat, clk_i, rst_ni,
    op.eval, out_valid_o)
  `MVWD_ASSERT_NOW(a_stall_only_for_eval, clk_i, rst_ni,
    in_stall_o, s1_valid_q && (s1_func_q == FUNC_EVAL) && out_valid_o && out_stall_i)

endmodule
